@@ hw/rtl/cbf_pkg.sv @@
// Shared types, constants and helper functions of the chain bending force unit.
// Used by the datapath, the controller and the top level; depends on nothing else.
`default_nettype none

package cbf_pkg;

  // Longest chain in monomers; a monomer that would get this index is dropped.
  localparam int unsigned MAX_CHAIN = 4096;
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned LP_W      = 31;
  // Width of a tangent difference term and of a force before saturation.
  localparam int unsigned TM_W      = 34;
  localparam int unsigned FRC_W     = 52;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_ZERO_BOND = 2'd1;
  localparam logic [1:0] STAT_SAT       = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE, OP_BOND, OP_SQA, OP_SQB, OP_SQRTA, OP_SQRTB, OP_UA, OP_UB,
    OP_DOT, OP_CI, OP_EN, OP_TM, OP_TP, OP_FMM, OP_FMD, OP_FPM, OP_FPD,
    OP_FIN, OP_ZERO, OP_COMMIT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] idx;
    logic       go;
    logic       wb;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic too_long;
    logic seen_zero;
    logic zero_len;
    logic unit_busy;
    logic out_free;
  } sts_t;

  function automatic logic is_mul_op(op_e op);
    return op inside {OP_SQA, OP_SQB, OP_DOT, OP_EN, OP_TM, OP_TP, OP_FMM, OP_FPM};
  endfunction

  function automatic logic is_iter_op(op_e op);
    return op inside {OP_SQRTA, OP_SQRTB, OP_UA, OP_UB, OP_FMD, OP_FPD};
  endfunction

  function automatic logic [31:0] mag32(logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // The magnitude of a tangent difference never exceeds 2^31.
  function automatic logic [31:0] mag_tm(logic signed [TM_W-1:0] v);
    logic signed [TM_W-1:0] m;
    m = v[TM_W-1] ? -v : v;
    return m[31:0];
  endfunction

  function automatic logic ovf32(logic signed [FRC_W-1:0] v);
    return !((&v[FRC_W-1:31]) || !(|v[FRC_W-1:31]));
  endfunction

  function automatic logic [31:0] sat32(logic signed [FRC_W-1:0] v);
    if (ovf32(v)) begin
      return v[FRC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cbf_div.sv @@
// Iterative unsigned divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// Stand-alone; used by the datapath for unit vectors and forces.
`default_nettype none

module cbf_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        busy_o,
  output logic [63:0] quo_o
);
  logic        busy_q;
  logic [5:0]  cnt_q;
  logic [31:0] rem_q;
  logic [31:0] dsr_q;
  logic [63:0] quo_q;
  logic [32:0] trial;
  logic        ge;

  assign trial = {rem_q, quo_q[63]};
  assign ge    = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dsr_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? 32'(trial - {1'b0, dsr_q}) : trial[31:0];
      quo_q <= {quo_q[62:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

@@ hw/rtl/cbf_sqrt.sv @@
// Iterative floor square root of a 64-bit value, one result bit per cycle.
// Stand-alone; used by the datapath for the bond lengths.
`default_nettype none

module cbf_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        busy_o,
  output logic [31:0] root_o
);
  logic        busy_q;
  logic [63:0] v_q;
  logic [63:0] res_q;
  logic [63:0] bit_q;
  logic [63:0] trial;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && bit_q == 64'd1) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= rad_i;
      res_q <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign busy_o = busy_q;
  assign root_o = res_q[31:0];

endmodule

`default_nettype wire

@@ hw/rtl/cbf_datapath.sv @@
// Datapath of the chain bending force unit: chain state, working registers,
// shared multiplier, divider and square root. Depends on cbf_pkg, cbf_div, cbf_sqrt.
`default_nettype none

module cbf_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_accept_i,
  input  logic signed [31:0]        pos_x_i,
  input  logic signed [31:0]        pos_y_i,
  input  logic signed [31:0]        pos_z_i,
  input  logic                      first_i,
  input  logic                      cfg_we_i,
  input  logic [cbf_pkg::LP_W-1:0]  stiffness_i,
  input  cbf_pkg::cmd_t             cmd_i,
  output cbf_pkg::sts_t             sts_o,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [cbf_pkg::IDX_W-1:0] joint_index_o,
  output logic [30:0]               energy_o,
  output logic [2:0][31:0]          fprev_o,
  output logic [2:0][31:0]          fmid_o,
  output logic [2:0][31:0]          fnext_o,
  output logic [1:0]                status_o
);
  import cbf_pkg::*;

  logic [LP_W-1:0]         lp_q;
  logic signed [31:0]      pos_q [3];
  logic                    first_q;
  logic signed [31:0]      lpos_q [3];
  logic signed [31:0]      lbond_q [3];
  logic                    clamp_q;
  logic [IDX_W-1:0]        seen_q;
  logic signed [31:0]      bnew_q [3];
  logic                    bsat_q;
  logic                    sat_q;
  logic [63:0]             sa_q, sb_q;
  logic [31:0]             da_q, db_q;
  logic signed [31:0]      ua_q [3];
  logic signed [31:0]      ub_q [3];
  logic signed [63:0]      dot_q;
  logic signed [31:0]      ci_q;
  logic [30:0]             en_q;
  logic signed [TM_W-1:0]  tm_q [3];
  logic signed [TM_W-1:0]  tp_q [3];
  logic [63:0]             num_q;
  logic                    numneg_q;
  logic signed [FRC_W-1:0] fm_q [3];
  logic signed [FRC_W-1:0] fp_q [3];
  logic [63:0]             prod_q;
  logic                    prodneg_q;
  logic                    out_valid_q;

  logic [IDX_W-1:0] joint_q;
  logic [30:0]      energy_q;
  logic [2:0][31:0] fprev_q, fmid_q, fnext_q;
  logic [1:0]       status_q;

  logic [1:0]              idx;
  logic signed [31:0]      bdiff [3];
  logic [2:0]              bovf;
  logic [31:0]             mul_a, mul_b;
  logic                    mul_neg;
  logic signed [64:0]      sprod;
  logic signed [64:0]      sprod_sh;
  logic signed [63:0]      dsh;
  logic signed [31:0]      ci_new;
  logic signed [32:0]      onemc;
  logic                    div_start, sqrt_start;
  logic [63:0]             div_dividend;
  logic [31:0]             div_divisor;
  logic                    div_busy, sqrt_busy;
  logic [63:0]             div_quo;
  logic [31:0]             sqrt_root;
  logic signed [FRC_W-1:0] mid [3];
  logic [8:0]              fovf;
  logic                    out_free;
  logic                    out_load;

  assign idx = cmd_i.idx;

  // New bond, saturated to 32 bits.
  always_comb begin
    logic signed [32:0] d;
    for (int i = 0; i < 3; i++) begin
      d = 33'(pos_q[i]) - 33'(lpos_q[i]);
      bovf[i] = d[32] ^ d[31];
      if (bovf[i]) begin
        bdiff[i] = d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        bdiff[i] = d[31:0];
      end
    end
  end

  assign onemc = 33'sd1073741824 - 33'(ci_q);

  // Operand selection of the shared multiplier (sign-magnitude).
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (cmd_i.op)
      OP_SQA: begin
        mul_a = mag32(lbond_q[idx]);
        mul_b = mag32(lbond_q[idx]);
      end
      OP_SQB: begin
        mul_a = mag32(bnew_q[idx]);
        mul_b = mag32(bnew_q[idx]);
      end
      OP_DOT: begin
        mul_a   = mag32(ua_q[idx]);
        mul_b   = mag32(ub_q[idx]);
        mul_neg = ua_q[idx][31] ^ ub_q[idx][31];
      end
      OP_EN: begin
        mul_a = {1'b0, lp_q};
        mul_b = onemc[31:0];
      end
      OP_TM: begin
        mul_a   = mag32(ci_q);
        mul_b   = mag32(ua_q[idx]);
        mul_neg = ci_q[31] ^ ua_q[idx][31];
      end
      OP_TP: begin
        mul_a   = mag32(ci_q);
        mul_b   = mag32(ub_q[idx]);
        mul_neg = ci_q[31] ^ ub_q[idx][31];
      end
      OP_FMM: begin
        mul_a   = {1'b0, lp_q};
        mul_b   = mag_tm(tm_q[idx]);
        mul_neg = tm_q[idx][TM_W-1];
      end
      OP_FPM: begin
        mul_a   = {1'b0, lp_q};
        mul_b   = mag_tm(tp_q[idx]);
        mul_neg = tp_q[idx][TM_W-1];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= 64'(mul_a) * 64'(mul_b);
    prodneg_q <= mul_neg;
  end

  assign sprod    = prodneg_q ? -$signed({1'b0, prod_q}) : $signed({1'b0, prod_q});
  assign sprod_sh = sprod >>> 30;

  // Cosine from the dot product of the unit vectors, clamped to [-1, 1].
  always_comb begin
    dsh = dot_q >>> 30;
    if (dsh > 64'sd1073741824) begin
      ci_new = 32'sd1073741824;
    end else if (dsh < -64'sd1073741824) begin
      ci_new = -32'sd1073741824;
    end else begin
      ci_new = 32'(dsh);
    end
  end

  // Divider and square root operands.
  always_comb begin
    div_dividend = '0;
    div_divisor  = da_q;
    case (cmd_i.op)
      OP_UA: div_dividend = {2'b00, mag32(lbond_q[idx]), 30'd0};
      OP_UB: begin
        div_dividend = {2'b00, mag32(bnew_q[idx]), 30'd0};
        div_divisor  = db_q;
      end
      OP_FMD: div_dividend = {14'd0, num_q[63:14]};
      OP_FPD: begin
        div_dividend = {14'd0, num_q[63:14]};
        div_divisor  = db_q;
      end
      default: begin
      end
    endcase
  end

  assign div_start  = cmd_i.go && (cmd_i.op inside {OP_UA, OP_UB, OP_FMD, OP_FPD});
  assign sqrt_start = cmd_i.go && ((cmd_i.op == OP_SQRTA && !sts_o.zero_len) ||
                                   cmd_i.op == OP_SQRTB);

  cbf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quo_o      (div_quo)
  );

  cbf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   ((cmd_i.op == OP_SQRTA) ? sa_q : sb_q),
    .busy_o  (sqrt_busy),
    .root_o  (sqrt_root)
  );

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      pos_q[0] <= pos_x_i;
      pos_q[1] <= pos_y_i;
      pos_q[2] <= pos_z_i;
      first_q  <= first_i;
    end
    if (cmd_i.go) begin
      case (cmd_i.op)
        OP_BOND: begin
          bnew_q <= bdiff;
          bsat_q <= |bovf;
          sat_q  <= (|bovf) | clamp_q;
          sa_q   <= '0;
          sb_q   <= '0;
          dot_q  <= '0;
        end
        OP_CI: ci_q <= ci_new;
        default: begin
        end
      endcase
    end
    if (cmd_i.wb) begin
      case (cmd_i.op)
        OP_SQA:   sa_q <= sa_q + prod_q;
        OP_SQB:   sb_q <= sb_q + prod_q;
        OP_SQRTA: da_q <= sqrt_root;
        OP_SQRTB: db_q <= sqrt_root;
        OP_UA: ua_q[idx] <= lbond_q[idx][31] ? -$signed(div_quo[31:0]) : $signed(div_quo[31:0]);
        OP_UB: ub_q[idx] <= bnew_q[idx][31] ? -$signed(div_quo[31:0]) : $signed(div_quo[31:0]);
        OP_DOT: dot_q <= dot_q + 64'(sprod);
        OP_EN: begin
          if (prod_q[63:61] != 3'd0) begin
            en_q  <= '1;
            sat_q <= 1'b1;
          end else begin
            en_q <= prod_q[60:30];
          end
        end
        OP_TM: tm_q[idx] <= TM_W'(sprod_sh) - TM_W'(ub_q[idx]);
        OP_TP: tp_q[idx] <= TM_W'(ua_q[idx]) - TM_W'(sprod_sh);
        OP_FMM, OP_FPM: begin
          num_q    <= prod_q;
          numneg_q <= prodneg_q;
        end
        OP_FMD: fm_q[idx] <= numneg_q ? -$signed(div_quo[FRC_W-1:0])
                                      : $signed(div_quo[FRC_W-1:0]);
        OP_FPD: fp_q[idx] <= numneg_q ? -$signed(div_quo[FRC_W-1:0])
                                      : $signed(div_quo[FRC_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  // Middle force and saturation of all nine force components.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mid[i]       = -fm_q[i] - fp_q[i];
      fovf[i]      = ovf32(fm_q[i]);
      fovf[3 + i]  = ovf32(mid[i]);
      fovf[6 + i]  = ovf32(fp_q[i]);
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = cmd_i.go && out_free && (cmd_i.op == OP_FIN || cmd_i.op == OP_ZERO);

  // Chain state, stiffness and the output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q        <= 31'd65536;
      lpos_q      <= '{default: '0};
      lbond_q     <= '{default: '0};
      clamp_q     <= 1'b0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        lp_q <= stiffness_i;
      end
      if (cmd_i.go && cmd_i.op == OP_COMMIT) begin
        lpos_q <= pos_q;
        if (first_q) begin
          lbond_q <= '{default: '0};
          clamp_q <= 1'b0;
          seen_q  <= '0;
        end else begin
          lbond_q <= bnew_q;
          clamp_q <= bsat_q;
          seen_q  <= seen_q + IDX_W'(1);
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      joint_q <= seen_q;
      if (cmd_i.op == OP_ZERO) begin
        energy_q <= '0;
        fprev_q  <= '0;
        fmid_q   <= '0;
        fnext_q  <= '0;
        status_q <= STAT_ZERO_BOND;
      end else begin
        energy_q <= en_q;
        for (int i = 0; i < 3; i++) begin
          fprev_q[i] <= sat32(fm_q[i]);
          fmid_q[i]  <= sat32(mid[i]);
          fnext_q[i] <= sat32(fp_q[i]);
        end
        status_q <= (sat_q || (|fovf)) ? STAT_SAT : STAT_OK;
      end
    end
  end

  assign sts_o.first     = first_q;
  assign sts_o.too_long  = seen_q >= IDX_W'(MAX_CHAIN - 1);
  assign sts_o.seen_zero = seen_q == '0;
  assign sts_o.zero_len  = (sa_q == '0) || (sb_q == '0);
  assign sts_o.unit_busy = div_busy || sqrt_busy;
  assign sts_o.out_free  = out_free;

  assign out_valid_o   = out_valid_q;
  assign joint_index_o = joint_q;
  assign energy_o      = energy_q;
  assign fprev_o       = fprev_q;
  assign fmid_o        = fmid_q;
  assign fnext_o       = fnext_q;
  assign status_o      = status_q;

endmodule

`default_nettype wire

@@ hw/rtl/cbf_ctrl.sv @@
// Controller of the chain bending force unit: steps the datapath through one joint.
// Depends on cbf_pkg.
`default_nettype none

module cbf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cbf_pkg::sts_t sts_i,
  output cbf_pkg::cmd_t cmd_o
);
  import cbf_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_GO, S_WAIT, S_WB} state_e;

  state_e     state_q;
  op_e        op_q;
  logic [1:0] idx_q;

  op_e        nxt_op;
  logic [1:0] nxt_idx;
  logic       to_idle;
  logic       last;

  assign last = idx_q == 2'd2;

  // Order of operations for one request.
  always_comb begin
    nxt_op  = OP_NONE;
    nxt_idx = '0;
    to_idle = 1'b0;
    case (op_q)
      OP_BOND: begin
        if (sts_i.first || (!sts_i.too_long && sts_i.seen_zero)) begin
          nxt_op = OP_COMMIT;
        end else if (sts_i.too_long) begin
          to_idle = 1'b1;
        end else begin
          nxt_op = OP_SQA;
        end
      end
      OP_SQA: begin
        nxt_op  = last ? OP_SQB : OP_SQA;
        nxt_idx = last ? 2'd0 : idx_q + 2'd1;
      end
      OP_SQB: begin
        nxt_op  = last ? OP_SQRTA : OP_SQB;
        nxt_idx = last ? 2'd0 : idx_q + 2'd1;
      end
      OP_SQRTA: nxt_op = OP_SQRTB;
      OP_SQRTB: nxt_op = OP_UA;
      OP_UA: begin
        nxt_op  = last ? OP_UB : OP_UA;
        nxt_idx = last ? 2'd0 : idx_q + 2'd1;
      end
      OP_UB: begin
        nxt_op  = last ? OP_DOT : OP_UB;
        nxt_idx = last ? 2'd0 : idx_q + 2'd1;
      end
      OP_DOT: begin
        nxt_op  = last ? OP_CI : OP_DOT;
        nxt_idx = last ? 2'd0 : idx_q + 2'd1;
      end
      OP_CI: nxt_op = OP_EN;
      OP_EN: nxt_op = OP_TM;
      OP_TM: begin
        nxt_op  = last ? OP_TP : OP_TM;
        nxt_idx = last ? 2'd0 : idx_q + 2'd1;
      end
      OP_TP: begin
        nxt_op  = last ? OP_FMM : OP_TP;
        nxt_idx = last ? 2'd0 : idx_q + 2'd1;
      end
      OP_FMM: begin
        nxt_op  = OP_FMD;
        nxt_idx = idx_q;
      end
      OP_FMD: begin
        nxt_op  = last ? OP_FPM : OP_FMM;
        nxt_idx = last ? 2'd0 : idx_q + 2'd1;
      end
      OP_FPM: begin
        nxt_op  = OP_FPD;
        nxt_idx = idx_q;
      end
      OP_FPD: begin
        nxt_op  = last ? OP_FIN : OP_FPM;
        nxt_idx = last ? 2'd0 : idx_q + 2'd1;
      end
      OP_FIN, OP_ZERO: nxt_op = OP_COMMIT;
      default: to_idle = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_NONE;
      idx_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_GO;
            op_q    <= OP_BOND;
            idx_q   <= '0;
          end
        end
        S_GO: begin
          if (op_q == OP_SQRTA && sts_i.zero_len) begin
            op_q <= OP_ZERO;
          end else if (is_mul_op(op_q)) begin
            state_q <= S_WB;
          end else if (is_iter_op(op_q)) begin
            state_q <= S_WAIT;
          end else if ((op_q == OP_FIN || op_q == OP_ZERO) && !sts_i.out_free) begin
            state_q <= S_GO;
          end else if (to_idle) begin
            state_q <= S_IDLE;
            op_q    <= OP_NONE;
          end else begin
            op_q  <= nxt_op;
            idx_q <= nxt_idx;
          end
        end
        S_WAIT: begin
          if (!sts_i.unit_busy) begin
            state_q <= S_WB;
          end
        end
        S_WB: begin
          state_q <= S_GO;
          op_q    <= nxt_op;
          idx_q   <= nxt_idx;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o = state_q == S_IDLE;
  assign cmd_o.op   = op_q;
  assign cmd_o.idx  = idx_q;
  assign cmd_o.go   = state_q == S_GO;
  assign cmd_o.wb   = state_q == S_WB;

`ifndef NO_ASSERTIONS
  a_accept_bond : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (cmd_o.go && cmd_o.op == OP_BOND))
    else $error("accepted request did not start with the bond step");

  a_wait_iter : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAIT) |-> is_iter_op(op_q))
    else $error("waiting on a unit for an operation that has none");

  a_wb_origin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB) |-> ($past(state_q) == S_GO || $past(state_q) == S_WAIT))
    else $error("write-back step entered out of order");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/chain_bending_force.sv @@
// Top level of the chain bending force unit: stream ports, controller and datapath.
// Depends on cbf_pkg, cbf_ctrl and cbf_datapath.
`default_nettype none

// Kratky-Porod bending unit. Monomer positions of a chain arrive one request at a
// time in Q16.16; a request with the chain-start flag in tuser begins a new chain.
// From the third monomer of a chain on, each request yields one result for the joint
// centered on the previous monomer: its index, the energy lp*(1-cos theta) and the
// force contributions on monomers n-1, n and n+1, plus a status in tuser (0 ok,
// 1 zero-length bond with all values zero, 2 something saturated). The first two
// monomers of a chain and monomers beyond the chain length limit give no result.
// One request is worked on at a time. A full joint runs, from one accepted request
// to the next, through the accept, the bond step, six squares and sixteen further
// multiplies, two 32-step square roots, twelve 64-step divisions (unit vectors and
// forces), which set the rate, and the cosine clamp, the output load and the chain
// state update. A request past the length limit ends after the bond step, the first
// or the second monomer of a chain after the bond step and the chain state update,
// and a zero-length bond gives its result after the squares, with no root or
// division. The finished result sits in an output register, so the next
// request is taken while it waits; the unit stalls only when a second result is
// ready before the first has been taken. The stiffness register is written through
// the cfg channel, which is always ready, and must only be written while the unit
// is idle.
module chain_bending_force (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // pos_x, pos_y, pos_z
  input  logic [0:0]   s_axis_tuser,   // first_of_chain
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [335:0] m_axis_tdata,   // joint_index, energy, fprev_x/y/z,
                                       // fmid_x/y/z, fnext_x/y/z, zero padding
  output logic [1:0]   m_axis_tuser,   // status
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [30:0]  cfg_data_i      // stiffness
);
  import cbf_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic             in_accept;
  logic [IDX_W-1:0] joint_index;
  logic [30:0]      energy;
  logic [2:0][31:0] fprev, fmid, fnext;

  assign in_accept   = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  cbf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cbf_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_accept_i   (in_accept),
    .pos_x_i       (s_axis_tdata[31:0]),
    .pos_y_i       (s_axis_tdata[63:32]),
    .pos_z_i       (s_axis_tdata[95:64]),
    .first_i       (s_axis_tuser[0]),
    .cfg_we_i      (cfg_valid_i),
    .stiffness_i   (cfg_data_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .joint_index_o (joint_index),
    .energy_o      (energy),
    .fprev_o       (fprev),
    .fmid_o        (fmid),
    .fnext_o       (fnext),
    .status_o      (m_axis_tuser)
  );

  // Result fields packed from the lowest bit up.
  assign m_axis_tdata = {5'd0,
                         fnext[2], fnext[1], fnext[0],
                         fmid[2], fmid[1], fmid[0],
                         fprev[2], fprev[1], fprev[0],
                         energy, joint_index};

endmodule

`default_nettype wire

@@ test/cbf_checker.sv @@
// Checker for the chain bending force unit: watches the monomer, joint and cfg channels,
// predicts every joint result and compares it field by field. Depends on cbf_pkg.
`timescale 1ns / 1ps

module cbf_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,
  input  logic [0:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [335:0] m_axis_tdata,
  input  logic [1:0]   m_axis_tuser,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_o,
  input  logic [30:0]  cfg_data_i,
  output int           fail_count_o,
  output int           joints_pending_o,
  output int           joints_seen_o
);
  import cbf_pkg::*;

  localparam longint ONE_Q30 = 64'sd1073741824;

  typedef struct packed {
    logic [11:0]      idx;
    logic [30:0]      energy;
    logic [8:0][31:0] force_v;   // prev x/y/z, mid x/y/z, next x/y/z
    logic [1:0]       status;
  } joint_t;

  joint_t joint_q[$];
  longint unsigned lp;
  longint prev_pos[3];
  longint prev_bond[3];
  int unsigned chain_len;
  bit bond_was_clamped;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned norm_sq(longint v[3]);
    longint unsigned s, m;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m = (v[i] < 0) ? -v[i] : v[i];
      s += m * m;
    end
    return s;
  endfunction

  function automatic longint clamp32(longint v, inout bit hit);
    if (v > 64'sd2147483647) begin
      hit = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      hit = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Bending energy and forces for the joint between bonds a and b.
  function automatic joint_t bend_joint(longint a[3], longint b[3], bit hit,
                                        logic [11:0] idx);
    joint_t j;
    longint unsigned sa, sb;
    longint da, db, dot, ci, e, tm, tp, mid;
    longint ua[3], ub[3], fm[3], fp[3];
    j = '0;
    j.idx = idx;
    sa = norm_sq(a);
    sb = norm_sq(b);
    if (sa == 0 || sb == 0) begin
      j.status = STAT_ZERO_BOND;
      return j;
    end
    da = longint'(root_floor(sa));
    db = longint'(root_floor(sb));
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      ua[i] = (a[i] * ONE_Q30) / da;
      ub[i] = (b[i] * ONE_Q30) / db;
      dot += ua[i] * ub[i];
    end
    ci = dot >>> 30;
    if (ci > ONE_Q30) ci = ONE_Q30;
    if (ci < -ONE_Q30) ci = -ONE_Q30;
    e = (longint'(lp) * (ONE_Q30 - ci)) >>> 30;
    if (e > 64'sd2147483647) begin
      e = 64'sd2147483647;
      hit = 1;
    end
    j.energy = e[30:0];
    for (int i = 0; i < 3; i++) begin
      tm = ((ci * ua[i]) >>> 30) - ub[i];
      tp = ua[i] - ((ci * ub[i]) >>> 30);
      fm[i] = (longint'(lp) * tm) / (da * 16384);
      fp[i] = (longint'(lp) * tp) / (db * 16384);
    end
    for (int i = 0; i < 3; i++) begin
      mid = -fm[i] - fp[i];
      j.force_v[i]     = 32'(clamp32(fm[i], hit));
      j.force_v[3 + i] = 32'(clamp32(mid, hit));
      j.force_v[6 + i] = 32'(clamp32(fp[i], hit));
    end
    j.status = hit ? STAT_SAT : STAT_OK;
    return j;
  endfunction

  task automatic take_monomer(logic [95:0] d, bit first);
    longint p[3], b[3];
    bit bhit;
    bhit = 0;
    for (int i = 0; i < 3; i++) p[i] = longint'($signed(d[32*i +: 32]));
    if (first) begin
      for (int i = 0; i < 3; i++) begin
        prev_pos[i] = p[i];
        prev_bond[i] = 0;
      end
      chain_len = 0;
      bond_was_clamped = 0;
    end else if (chain_len < MAX_CHAIN - 1) begin
      for (int i = 0; i < 3; i++) b[i] = clamp32(p[i] - prev_pos[i], bhit);
      if (chain_len >= 1)
        joint_q.push_back(bend_joint(prev_bond, b, bhit || bond_was_clamped,
                                     chain_len[11:0]));
      for (int i = 0; i < 3; i++) begin
        prev_bond[i] = b[i];
        prev_pos[i] = p[i];
      end
      bond_was_clamped = bhit;
      chain_len++;
    end
  endtask

  task automatic compare_joint(logic [335:0] d, logic [1:0] st);
    joint_t want;
    string fname[9] = '{"fprev_x", "fprev_y", "fprev_z", "fmid_x", "fmid_y", "fmid_z",
                        "fnext_x", "fnext_y", "fnext_z"};
    if (joint_q.size() == 0) begin
      $error("joint result with no request pending: tdata %h", d);
      fail_count_o++;
      return;
    end
    want = joint_q.pop_front();
    if (d[11:0] !== want.idx) begin
      $error("joint_index: expected %0d, got %0d", want.idx, d[11:0]);
      fail_count_o++;
    end
    if (d[42:12] !== want.energy) begin
      $error("energy: expected %h, got %h", want.energy, d[42:12]);
      fail_count_o++;
    end
    for (int i = 0; i < 9; i++) begin
      if (d[43 + 32*i +: 32] !== want.force_v[i]) begin
        $error("%s: expected %h, got %h", fname[i], want.force_v[i], d[43 + 32*i +: 32]);
        fail_count_o++;
      end
    end
    if (st !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, st);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp = 65536;
      for (int i = 0; i < 3; i++) begin
        prev_pos[i] = 0;
        prev_bond[i] = 0;
      end
      chain_len = 0;
      bond_was_clamped = 0;
      joint_q.delete();
      fail_count_o = 0;
      joints_seen_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) lp = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) take_monomer(s_axis_tdata, s_axis_tuser[0]);
      if (m_axis_tvalid && m_axis_tready) begin
        compare_joint(m_axis_tdata, m_axis_tuser);
        joints_seen_o++;
      end
    end
    joints_pending_o = joint_q.size();
  end

  final begin
    if (joint_q.size() != 0) $display("note: %0d joints never arrived", joint_q.size());
  end

endmodule

@@ test/tb_top.sv @@
// Testbench top of the chain bending force unit: clock, reset, monomer stimulus and verdict.
// Depends on cbf_pkg, chain_bending_force and cbf_checker.
`timescale 1ns / 1ps

module tb_top;
  import cbf_pkg::*;

  // About two thousand requests are sent; the cycle limit is set well above what they need.
  localparam longint CYCLE_LIMIT = 64'd10_000_000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata;    // pos_x, pos_y, pos_z
  logic [0:0]   s_axis_tuser;    // first_of_chain
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [335:0] m_axis_tdata;    // joint_index, energy, fprev, fmid, fnext, padding
  logic [1:0]   m_axis_tuser;    // status
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [30:0]  cfg_data_i;      // stiffness

  int  fail_count, joints_pending, joints_seen;
  int  monomers_sent;
  bit  steady;                   // when set, neither side idles
  longint cycle_count = 0;
  logic [31:0] walk [3];

  chain_bending_force dut (.*);

  cbf_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .fail_count_o(fail_count), .joints_pending_o(joints_pending),
    .joints_seen_o(joints_seen)
  );

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // The joint side stalls at random, except in the steady stretch.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= 26);
    end
  end

  // Hard stop in case the unit hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Sends one monomer request. Called just after a rising edge; returns just after
  // the edge that accepted it, with tvalid still high.
  task automatic send_monomer(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit first);
    if (!steady && $urandom_range(99) < 26) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    s_axis_tuser  <= first;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    monomers_sent++;
  endtask

  // Waits until every joint has arrived, then lets a monomer with no result finish.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (joints_pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_stiffness(logic [30:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // One random step of a chain: mostly a short walk with steps of varied size,
  // sometimes a repeated position or a fully random one.
  task automatic random_step(bit first);
    int pick, k;
    pick = $urandom_range(99);
    for (int i = 0; i < 3; i++) begin
      if (pick < 8) begin
        // repeated position gives a zero-length bond
      end else if (pick < 18) begin
        walk[i] = $urandom();
      end else begin
        k = $urandom_range(30);
        walk[i] = walk[i] + ($signed($urandom()) >>> (31 - k));
      end
    end
    send_monomer(walk[0], walk[1], walk[2], first);
  endtask

  task automatic random_phase(int n_items);
    int left, len;
    left = n_items;
    while (left > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(3, 24);
      for (int m = 0; m < len && left > 0; m++) begin
        random_step(m == 0);
        left--;
      end
    end
  endtask

  initial begin
    logic [30:0] lp_set [5];
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    monomers_sent = 0;
    steady        = 1'b0;
    for (int i = 0; i < 3; i++) walk[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset stiffness. No chain start yet, so the chain
    // begins at the origin.
    send_monomer(32'h0001_0000, 32'h0, 32'h0, 1'b0);
    send_monomer(32'h0002_0000, 32'h0, 32'h0, 1'b0);          // straight joint
    send_monomer(32'h0002_0000, 32'h0001_0000, 32'h0, 1'b0);  // right angle
    send_monomer(32'h0002_0000, 32'h0001_0000, 32'h0, 1'b0);  // zero-length bond
    send_monomer(32'h0001_0000, 32'h0001_0000, 32'h0, 1'b0);  // bond after a zero one
    send_monomer(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0); // bond saturates
    send_monomer(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_monomer(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    // New chain with a full reversal.
    send_monomer(32'h0, 32'h0, 32'h0, 1'b1);
    send_monomer(32'h0, 32'h0, 32'h0003_0000, 1'b0);
    send_monomer(32'h0, 32'h0, 32'h0, 1'b0);                  // cos = -1
    send_monomer(32'h0, 32'h0, 32'h0, 1'b0);
    send_monomer(32'h0000_0001, 32'h0, 32'h0, 1'b0);          // tiny bonds
    send_monomer(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 1'b0);
    send_monomer(32'h0, 32'h0, 32'h0, 1'b1);                  // one-monomer chain
    send_monomer(32'h1234_5678, 32'h0, 32'h0, 1'b1);          // two-monomer chain
    send_monomer(32'h1234_0000, 32'h0, 32'h0, 1'b0);
    drain();

    // Random phases over several stiffness settings, the extremes among them.
    // Every phase ends with the sender paused until every joint has come.
    lp_set = '{31'd0, 31'h7FFF_FFFF, 31'd65536, 31'($urandom()), 31'd1};
    for (int ph = 0; ph < 5; ph++) begin
      write_stiffness(lp_set[ph]);
      steady = (ph == 2);
      random_phase(400);
      drain();
    end
    steady = 1'b0;
    repeat (2000) @(posedge clk_i);

    $display("covered %0d monomer requests and %0d joint results over several stiffness values,",
             monomers_sent, joints_seen);
    $display("including zero-length and saturated bonds and very short chains");
    if (fail_count == 0 && joints_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
